@@ src/scss_pkg.sv @@
package scss_pkg;

    localparam int unsigned SEC_W  = 6;
    localparam int unsigned MIN_W  = 6;
    localparam int unsigned HOUR_W = 5;
    localparam int unsigned BTN_W  = 8;
    localparam int unsigned MS_W   = 16;
    localparam int unsigned LOCK_W = 10;

    localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
    localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
    localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;
    localparam logic [MS_W-1:0]   MS_MAX    = 16'hFFFF;
    localparam logic [LOCK_W-1:0] LOCK_RESET = 10'd100;

    // Input mode codes
    localparam logic [1:0] MODE_SEC = 2'd0;
    localparam logic [1:0] MODE_MS  = 2'd1;
    localparam logic [1:0] MODE_BTN = 2'd2;

    // Button codes
    localparam logic [BTN_W-1:0] BTN_HOUR_UP = 8'h01;
    localparam logic [BTN_W-1:0] BTN_HOUR_DN = 8'h02;
    localparam logic [BTN_W-1:0] BTN_MIN_UP  = 8'h04;
    localparam logic [BTN_W-1:0] BTN_MIN_DN  = 8'h08;
    localparam logic [BTN_W-1:0] BTN_SEC_UP  = 8'h10;
    localparam logic [BTN_W-1:0] BTN_SEC_DN  = 8'h20;
    localparam logic [BTN_W-1:0] BTN_STOP    = 8'h40;
    localparam logic [BTN_W-1:0] BTN_START   = 8'h80;

    typedef enum logic [1:0] {
        KIND_SEC,
        KIND_MS,
        KIND_BTN,
        KIND_NONE
    } t_kind;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_HOUR_UP,
        OP_HOUR_DN,
        OP_MIN_UP,
        OP_MIN_DN,
        OP_SEC_UP,
        OP_SEC_DN,
        OP_STOP,
        OP_START
    } t_op;

    typedef struct packed {
        t_kind            kind;
        t_op              op;
        logic [BTN_W-1:0] buttons;
    } t_cmd;

    typedef struct packed {
        logic              running;
        logic [HOUR_W-1:0] hours;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
    } t_res;

    // Tens digit of a value below 60
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        if (v >= 6'd50) begin
            t = 3'd5;
        end else if (v >= 6'd40) begin
            t = 3'd4;
        end else if (v >= 6'd30) begin
            t = 3'd3;
        end else if (v >= 6'd20) begin
            t = 3'd2;
        end else if (v >= 6'd10) begin
            t = 3'd1;
        end else begin
            t = 3'd0;
        end
        return t;
    endfunction

    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [5:0] tens_x10;
        logic [5:0] diff;
        tens_x10 = 6'(tens_of(v)) * 6'd10;
        diff     = v - tens_x10;
        return diff[3:0];
    endfunction

    // Segment a in bit 0 up to g in bit 6, dot always dark
    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        unique case (d)
            4'd0:    s = 8'b0011_1111;
            4'd1:    s = 8'b0000_0110;
            4'd2:    s = 8'b0101_1011;
            4'd3:    s = 8'b0100_1111;
            4'd4:    s = 8'b0110_0110;
            4'd5:    s = 8'b0110_1101;
            4'd6:    s = 8'b0111_1101;
            4'd7:    s = 8'b0000_0111;
            4'd8:    s = 8'b0111_1111;
            4'd9:    s = 8'b0110_1111;
            default: s = 8'b0000_0000;
        endcase
        return s;
    endfunction

endpackage

@@ src/scss_front.sv @@
module scss_front import scss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       i_mode,
    input  logic [BTN_W-1:0] i_buttons,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  logic             i_cmd_take
);

    t_cmd       r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_cmd       w_cmd;
    logic       w_in, w_out;

    // classify the incoming word
    always_comb begin
        w_cmd.buttons = i_buttons;
        unique case (i_mode)
            MODE_SEC: w_cmd.kind = KIND_SEC;
            MODE_MS:  w_cmd.kind = KIND_MS;
            MODE_BTN: w_cmd.kind = KIND_BTN;
            default:  w_cmd.kind = KIND_NONE;
        endcase
        unique case (i_buttons)
            BTN_HOUR_UP: w_cmd.op = OP_HOUR_UP;
            BTN_HOUR_DN: w_cmd.op = OP_HOUR_DN;
            BTN_MIN_UP:  w_cmd.op = OP_MIN_UP;
            BTN_MIN_DN:  w_cmd.op = OP_MIN_DN;
            BTN_SEC_UP:  w_cmd.op = OP_SEC_UP;
            BTN_SEC_DN:  w_cmd.op = OP_SEC_DN;
            BTN_STOP:    w_cmd.op = OP_STOP;
            BTN_START:   w_cmd.op = OP_START;
            default:     w_cmd.op = OP_NONE;
        endcase
    end

    assign full        = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd];
    assign w_in        = push && !full;
    assign w_out       = i_cmd_take && o_cmd_valid;
    assign n_count     = r_count + 2'(w_in) - 2'(w_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_in) begin
                r_wr <= !r_wr;
            end
            if (w_out) begin
                r_rd <= !r_rd;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wr] <= w_cmd;
        end
    end

endmodule

@@ src/scss_back.sv @@
module scss_back import scss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LOCK_W-1:0] i_lockout_ms,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_take,
    output logic              empty,
    input  logic              pop,
    output logic              o_running,
    output logic [HOUR_W-1:0] o_hours,
    output logic [MIN_W-1:0]  o_minutes,
    output logic [SEC_W-1:0]  o_seconds,
    output logic [7:0]        o_seg_hour_tens,
    output logic [7:0]        o_seg_hour_ones,
    output logic [7:0]        o_seg_minute_tens,
    output logic [7:0]        o_seg_minute_ones,
    output logic [7:0]        o_seg_second_tens,
    output logic [7:0]        o_seg_second_ones
);

    logic              r_run;
    logic [HOUR_W-1:0] r_h;
    logic [MIN_W-1:0]  r_m;
    logic [SEC_W-1:0]  r_s;
    logic [BTN_W-1:0]  r_last;
    logic [MS_W-1:0]   r_ms;

    logic              n_run;
    logic [HOUR_W-1:0] n_h;
    logic [MIN_W-1:0]  n_m;
    logic [SEC_W-1:0]  n_s;
    logic [BTN_W-1:0]  n_last;
    logic [MS_W-1:0]   n_ms;

    t_res       r_res [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;
    logic       w_out;
    logic       w_btn_ok;
    t_op        w_op;
    logic       inc_s, dec_s, inc_m, dec_m, inc_h, dec_h;
    t_res       w_head;

    assign o_cmd_take = i_cmd_valid && (r_count != 2'd2);
    assign w_out      = pop && !empty;
    assign empty      = (r_count == 2'd0);

    assign w_btn_ok = (i_cmd.kind == KIND_BTN)
                   && (r_ms > MS_W'(i_lockout_ms))
                   && (i_cmd.buttons != r_last);
    assign w_op = w_btn_ok ? i_cmd.op : OP_NONE;

    // carry and borrow ripple up from seconds to hours
    assign inc_s = ((i_cmd.kind == KIND_SEC) && r_run) || (w_op == OP_SEC_UP);
    assign dec_s = (w_op == OP_SEC_DN);
    assign inc_m = (w_op == OP_MIN_UP) || (inc_s && (r_s == SEC_LAST));
    assign dec_m = (w_op == OP_MIN_DN) || (dec_s && (r_s == '0));
    assign inc_h = (w_op == OP_HOUR_UP) || (inc_m && (r_m == MIN_LAST));
    assign dec_h = (w_op == OP_HOUR_DN) || (dec_m && (r_m == '0));

    always_comb begin
        n_s = r_s;
        if (inc_s) begin
            n_s = (r_s == SEC_LAST) ? '0 : r_s + 1'b1;
        end else if (dec_s) begin
            n_s = (r_s == '0) ? SEC_LAST : r_s - 1'b1;
        end
        n_m = r_m;
        if (inc_m) begin
            n_m = (r_m == MIN_LAST) ? '0 : r_m + 1'b1;
        end else if (dec_m) begin
            n_m = (r_m == '0) ? MIN_LAST : r_m - 1'b1;
        end
        n_h = r_h;
        if (inc_h) begin
            n_h = (r_h == HOUR_LAST) ? '0 : r_h + 1'b1;
        end else if (dec_h) begin
            n_h = (r_h == '0) ? HOUR_LAST : r_h - 1'b1;
        end

        n_run = r_run;
        if (w_op == OP_STOP) begin
            n_run = 1'b0;
        end else if (w_op == OP_START) begin
            n_run = 1'b1;
        end

        n_last = r_last;
        n_ms   = r_ms;
        if (w_btn_ok) begin
            n_last = i_cmd.buttons;
            n_ms   = '0;
        end else if ((i_cmd.kind == KIND_MS) && (r_ms != MS_MAX)) begin
            n_ms = r_ms + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b1;
            r_h     <= '0;
            r_m     <= '0;
            r_s     <= '0;
            r_last  <= '0;
            r_ms    <= '0;
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (o_cmd_take) begin
                r_run  <= n_run;
                r_h    <= n_h;
                r_m    <= n_m;
                r_s    <= n_s;
                r_last <= n_last;
                r_ms   <= n_ms;
                r_wr   <= !r_wr;
            end
            if (w_out) begin
                r_rd <= !r_rd;
            end
            r_count <= r_count + 2'(o_cmd_take) - 2'(w_out);
        end
    end

    // result queue holds the state after each word
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_res[r_wr] <= '{running: n_run, hours: n_h, minutes: n_m, seconds: n_s};
        end
    end

    assign w_head    = r_res[r_rd];
    assign o_running = w_head.running;
    assign o_hours   = w_head.hours;
    assign o_minutes = w_head.minutes;
    assign o_seconds = w_head.seconds;

    assign o_seg_hour_tens   = seg_of(4'(tens_of(6'(w_head.hours))));
    assign o_seg_hour_ones   = seg_of(ones_of(6'(w_head.hours)));
    assign o_seg_minute_tens = seg_of(4'(tens_of(w_head.minutes)));
    assign o_seg_minute_ones = seg_of(ones_of(w_head.minutes));
    assign o_seg_second_tens = seg_of(4'(tens_of(w_head.seconds)));
    assign o_seg_second_ones = seg_of(ones_of(w_head.seconds));

endmodule

@@ src/settable_clock_seven_segment.sv @@
// Time-of-day clock with a six-digit seven-segment readout. Push one word per
// event: a one-second tick, a one-millisecond tick or a button sample; every
// word yields exactly one result showing the running flag, hours, minutes,
// seconds and the six segment bytes after that word has taken effect. A button
// change counts only when it differs from the last accepted sample and more
// than lockout_ms millisecond ticks have passed since then (register at byte
// address 0, reset 100). Time is held as separate hour, minute and second
// counters, so every adjustment wraps across the day with no division. Each
// word is classified into the front-end command queue and then executed by the
// back end, which queues its result; both sides sustain one word per clock
// while results are popped, since a full result queue stalls the back end.
module settable_clock_seven_segment import scss_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input queue
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_mode,
    input  logic [BTN_W-1:0]  i_buttons,
    // result queue
    output logic              empty,
    input  logic              pop,
    output logic              o_running,
    output logic [HOUR_W-1:0] o_hours,
    output logic [MIN_W-1:0]  o_minutes,
    output logic [SEC_W-1:0]  o_seconds,
    output logic [7:0]        o_seg_hour_tens,
    output logic [7:0]        o_seg_hour_ones,
    output logic [7:0]        o_seg_minute_tens,
    output logic [7:0]        o_seg_minute_ones,
    output logic [7:0]        o_seg_second_tens,
    output logic [7:0]        o_seg_second_ones,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [0:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [LOCK_W-1:0] r_lockout;
    logic              w_cmd_valid;
    logic              w_cmd_take;
    t_cmd              w_cmd;

    // Register file: a single lockout register, written in the access phase
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? 32'(r_lockout) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout <= LOCK_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == 1'b0)) begin
            r_lockout <= pwdata[LOCK_W-1:0];
        end
    end

    // Front end: classify words and hold them in a short command queue
    scss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_mode      (i_mode),
        .i_buttons   (i_buttons),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    // Back end: apply commands to the clock state and queue the results
    scss_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_lockout_ms      (r_lockout),
        .i_cmd_valid       (w_cmd_valid),
        .i_cmd             (w_cmd),
        .o_cmd_take        (w_cmd_take),
        .empty             (empty),
        .pop               (pop),
        .o_running         (o_running),
        .o_hours           (o_hours),
        .o_minutes         (o_minutes),
        .o_seconds         (o_seconds),
        .o_seg_hour_tens   (o_seg_hour_tens),
        .o_seg_hour_ones   (o_seg_hour_ones),
        .o_seg_minute_tens (o_seg_minute_tens),
        .o_seg_minute_ones (o_seg_minute_ones),
        .o_seg_second_tens (o_seg_second_tens),
        .o_seg_second_ones (o_seg_second_ones)
    );

endmodule
